// ===== rtl/chacha20_seekable_stream_cipher_unit_defines.svh =====
// Assertion macros shared by the cipher RTL.
`ifndef CHACHA20_SEEKABLE_STREAM_CIPHER_UNIT_DEFINES_SVH
`define CHACHA20_SEEKABLE_STREAM_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication under a synchronous reset.
`define CC20_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under a synchronous reset.
`define CC20_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cc20_pkg.sv =====
// Shared types and constants of the ChaCha20 stream cipher unit.
package cc20_pkg;

   localparam int DOUBLE_ROUNDS_DEF = 10;
   localparam int POSITION_BITS_DEF = 48;
   localparam int NUM_REGS          = 6;
   localparam int REG_W             = 64;
   localparam int CSR_ADDR_W        = 6;
   localparam int WORD_W            = 32;
   localparam int KS_WORDS          = 16;
   localparam int WORD_IDX_W        = 4;

   localparam logic [2:0] REG_KEY0  = 3'd0;
   localparam logic [2:0] REG_CTR   = 3'd4;
   localparam logic [2:0] REG_NONCE = 3'd5;

   // "expand 32-byte k", word 0 in the low slot
   localparam logic [3:0][WORD_W-1:0] SIGMA = {
      32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
   };

   typedef struct packed {
      logic [7:0]  data_in;
      logic        seek;
      logic [47:0] position;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       last_out;
   } rsp_type;

   typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_type;

   typedef struct packed {
      logic                  we;
      logic [WORD_IDX_W-1:0] addr;
      logic [WORD_W-1:0]     data;
   } ks_wr_type;

endpackage

// ===== rtl/cc20_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cc20_ram #(
   parameter int WIDTH = cc20_pkg::WORD_W,
   parameter int DEPTH = cc20_pkg::KS_WORDS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cc20_gen.sv =====
// ChaCha20 block function sequencer over a 16-word working RAM.
`include "chacha20_seekable_stream_cipher_unit_defines.svh"

module cc20_gen #(
   parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF,
   parameter int POSITION_BITS = cc20_pkg::POSITION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [POSITION_BITS-7:0] blk_index,
   input  cc20_pkg::cfg_regs_type   cfg,
   output logic                     done,
   output cc20_pkg::ks_wr_type      ks_wr
);

   import cc20_pkg::*;

   localparam int DR_W = $clog2(DOUBLE_ROUNDS);

   typedef enum logic [1:0] {G_IDLE, G_INIT, G_QR, G_FINAL} gen_state_type;

   gen_state_type           state_ff;
   logic [4:0]              cnt_ff;
   logic [2:0]              qi_ff;
   logic [DR_W-1:0]         dr_ff;
   logic [WORD_W-1:0]       a_ff, b_ff, c_ff, d_ff;
   logic [63:0]             ctr_ff;
   logic                    done_ff;

   logic                    rr_wr_en, rr_rd_en;
   logic [WORD_IDX_W-1:0]   rr_wr_addr, rr_rd_addr;
   logic [WORD_W-1:0]       rr_wr_data, rr_rd_data;
   logic [WORD_IDX_W-1:0]   iw_idx;
   logic [WORD_W-1:0]       init_w;
   logic [1:0]              slot_wr;
   logic [WORD_W-1:0]       s_ab, s_cd;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
      return (x << n) | (x >> (WORD_W - n));
   endfunction

   // Column rounds use lane qi; diagonal rounds shift each row by its slot.
   function automatic logic [WORD_IDX_W-1:0] qr_index(input logic [2:0] qi,
                                                       input logic [1:0] slot);
      logic [1:0] lane;
      lane = qi[2] ? (qi[1:0] + slot) : qi[1:0];
      return {slot, lane};
   endfunction

   function automatic logic [WORD_W-1:0] init_word(input cfg_regs_type regs,
                                                    input logic [63:0] ctr,
                                                    input logic [WORD_IDX_W-1:0] idx);
      logic [63:0] pair;
      if (idx[3:2] == 2'b00) begin
         return SIGMA[idx[1:0]];
      end
      if (idx < 4'd12) begin
         pair = regs[REG_KEY0 + 3'(idx[3:1]) - 3'd2];
      end else if (idx[3:1] == 3'd6) begin
         pair = ctr;
      end else begin
         pair = regs[REG_NONCE];
      end
      return idx[0] ? pair[63:32] : pair[31:0];
   endfunction

   assign s_ab    = a_ff + b_ff;
   assign s_cd    = c_ff + d_ff;
   assign slot_wr = 2'(cnt_ff - 5'd9);
   assign iw_idx  = (state_ff == G_FINAL) ? (cnt_ff[3:0] - 4'd1) : cnt_ff[3:0];
   assign init_w  = init_word(cfg, ctr_ff, iw_idx);

   always_comb begin
      rr_wr_en   = 1'b0;
      rr_wr_addr = cnt_ff[3:0];
      rr_wr_data = init_w;
      rr_rd_en   = 1'b0;
      rr_rd_addr = cnt_ff[3:0];
      unique case (state_ff)
         G_IDLE: begin
         end
         G_INIT: begin
            rr_wr_en = 1'b1;
         end
         G_QR: begin
            if (cnt_ff < 5'd4) begin
               rr_rd_en   = 1'b1;
               rr_rd_addr = qr_index(qi_ff, cnt_ff[1:0]);
            end
            if (cnt_ff >= 5'd9) begin
               rr_wr_en   = 1'b1;
               rr_wr_addr = qr_index(qi_ff, slot_wr);
               case (slot_wr)
                  2'd0:    rr_wr_data = a_ff;
                  2'd1:    rr_wr_data = b_ff;
                  2'd2:    rr_wr_data = c_ff;
                  default: rr_wr_data = d_ff;
               endcase
            end
         end
         G_FINAL: begin
            rr_rd_en = (cnt_ff < 5'd16);
         end
         default: begin
         end
      endcase
   end

   // Feed-forward: add the input word to the finished round word.
   always_comb begin
      ks_wr.we   = (state_ff == G_FINAL) && (cnt_ff != 5'd0);
      ks_wr.addr = iw_idx;
      ks_wr.data = rr_rd_data + init_w;
   end

   cc20_ram #(
      .WIDTH (WORD_W),
      .DEPTH (KS_WORDS)
   ) u_round_ram (
      .clock   (clock),
      .wr_en   (rr_wr_en),
      .wr_addr (rr_wr_addr),
      .wr_data (rr_wr_data),
      .rd_en   (rr_rd_en),
      .rd_addr (rr_rd_addr),
      .rd_data (rr_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         cnt_ff   <= '0;
         qi_ff    <= '0;
         dr_ff    <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            G_IDLE: begin
               if (start) begin
                  ctr_ff   <= cfg[REG_CTR] + 64'(blk_index);
                  cnt_ff   <= '0;
                  state_ff <= G_INIT;
               end
            end
            G_INIT: begin
               if (cnt_ff == 5'd15) begin
                  cnt_ff   <= '0;
                  qi_ff    <= '0;
                  dr_ff    <= '0;
                  state_ff <= G_QR;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            G_QR: begin
               case (cnt_ff)
                  5'd1: a_ff <= rr_rd_data;
                  5'd2: b_ff <= rr_rd_data;
                  5'd3: c_ff <= rr_rd_data;
                  5'd4: d_ff <= rr_rd_data;
                  5'd5: begin
                     a_ff <= s_ab;
                     d_ff <= rotl(d_ff ^ s_ab, 16);
                  end
                  5'd6: begin
                     c_ff <= s_cd;
                     b_ff <= rotl(b_ff ^ s_cd, 12);
                  end
                  5'd7: begin
                     a_ff <= s_ab;
                     d_ff <= rotl(d_ff ^ s_ab, 8);
                  end
                  5'd8: begin
                     c_ff <= s_cd;
                     b_ff <= rotl(b_ff ^ s_cd, 7);
                  end
                  default: begin
                  end
               endcase
               if (cnt_ff == 5'd12) begin
                  cnt_ff <= '0;
                  if (qi_ff == 3'd7) begin
                     qi_ff <= '0;
                     if (dr_ff == DR_W'(DOUBLE_ROUNDS - 1)) begin
                        state_ff <= G_FINAL;
                     end else begin
                        dr_ff <= dr_ff + 1'b1;
                     end
                  end else begin
                     qi_ff <= qi_ff + 3'd1;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            G_FINAL: begin
               if (cnt_ff == 5'd16) begin
                  cnt_ff   <= '0;
                  done_ff  <= 1'b1;
                  state_ff <= G_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            default: begin
               state_ff <= G_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;

   `CC20_ASSERT_IMPL(a_rr_no_overlap, clock, reset, rr_rd_en && rr_wr_en, rr_rd_addr != rr_wr_addr, "round RAM read and write hit the same word")
   `CC20_ASSERT_IMPL(a_start_idle, clock, reset, start, state_ff == G_IDLE, "block start while busy")
   `CC20_ASSERT_IMPL(a_done_idle, clock, reset, done_ff, state_ff == G_IDLE, "done raised while busy")
   `CC20_ASSERT_IMPL(a_ks_final, clock, reset, ks_wr.we, state_ff == G_FINAL, "keystream write outside feed-forward pass")

endmodule

// ===== rtl/chacha20_seekable_stream_cipher_unit.sv =====
// ChaCha20 keystream XOR unit, 64-bit counter layout, with seekable position.
//
// Usage: each request on req_ carries one byte, a seek flag with a position and a
// last marker; each request yields exactly one response on rsp_ (byte XOR keystream,
// last copied through), in request order. Key, initial counter and nonce are
// written over the APB-style port at byte address 8*i; a write to one of the six
// registers clears the cache. One 64-byte keystream block is held in a 16-word
// RAM. A request whose block is cached is served by a RAM read, then a load of
// the output register. A request that needs a new block first runs the block
// function on a second 16-word RAM, one quarter round at a time. One request is
// in flight at a time; req_ready is high only when the unit is idle. The response
// sits in an output register: a stalled rsp_ready holds it, and the next request
// is still taken and worked on until its own response needs that register. Reset
// clears the registers, the position and the cache valid flag; no clearing pass runs.
`include "chacha20_seekable_stream_cipher_unit_defines.svh"

module chacha20_seekable_stream_cipher_unit #(
   parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF,
   parameter int POSITION_BITS = cc20_pkg::POSITION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  cc20_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cc20_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cc20_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [cc20_pkg::REG_W-1:0]      pwdata,
   output logic [cc20_pkg::REG_W-1:0]      prdata,
   output logic                            pready
);

   import cc20_pkg::*;

   localparam int PB    = POSITION_BITS;
   localparam int BLK_W = POSITION_BITS - 6;

   typedef enum logic [1:0] {S_IDLE, S_GEN, S_LOOK} top_state_type;

   top_state_type         state_ff;
   cfg_regs_type          cfg_ff;
   logic [PB-1:0]         pos_ff;
   logic [BLK_W-1:0]      cached_ff;
   logic                  valid_ff;
   logic [BLK_W-1:0]      blk_ff;
   logic                  start_ff;
   logic [1:0]            lane_ff;
   logic [WORD_IDX_W-1:0] word_ff;
   logic [7:0]            data_ff;
   logic                  last_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic                  req_accept;
   logic [PB-1:0]         pos_eff;
   logic [BLK_W-1:0]      blk_eff;
   logic                  hit;
   logic [2:0]            csr_idx;
   logic                  csr_wr;
   logic                  csr_hit;
   logic                  gen_done;
   ks_wr_type             ks_wr;
   logic                  ks_rd_en;
   logic [WORD_IDX_W-1:0] ks_rd_addr;
   logic [WORD_W-1:0]     ks_rd_data;
   logic [7:0]            ks_byte;
   logic                  load;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign pos_eff    = req_data.seek ? PB'(req_data.position) : pos_ff;
   assign blk_eff    = pos_eff[PB-1:6];
   assign hit        = valid_ff && (blk_eff == cached_ff);

   assign csr_idx = paddr[5:3];
   assign csr_wr  = psel && penable && pwrite;
   assign csr_hit = (csr_idx < 3'(NUM_REGS));
   assign prdata  = csr_hit ? cfg_ff[csr_idx] : '0;
   assign pready  = 1'b1;

   // Read the cached word at once on a hit, or right after a fresh block lands.
   assign ks_rd_en   = (req_accept && hit) || ((state_ff == S_GEN) && gen_done);
   assign ks_rd_addr = (state_ff == S_IDLE) ? pos_eff[5:2] : word_ff;
   assign ks_byte    = ks_rd_data[{lane_ff, 3'b000} +: 8];
   assign load       = (state_ff == S_LOOK) && (!rsp_valid_ff || rsp_ready);

   cc20_ram #(
      .WIDTH (WORD_W),
      .DEPTH (KS_WORDS)
   ) u_ks_ram (
      .clock   (clock),
      .wr_en   (ks_wr.we),
      .wr_addr (ks_wr.addr),
      .wr_data (ks_wr.data),
      .rd_en   (ks_rd_en),
      .rd_addr (ks_rd_addr),
      .rd_data (ks_rd_data)
   );

   cc20_gen #(
      .DOUBLE_ROUNDS (DOUBLE_ROUNDS),
      .POSITION_BITS (POSITION_BITS)
   ) u_gen (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .blk_index (blk_ff),
      .cfg       (cfg_ff),
      .done      (gen_done),
      .ks_wr     (ks_wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cfg_ff       <= '0;
         pos_ff       <= '0;
         cached_ff    <= '0;
         valid_ff     <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (csr_wr && csr_hit) begin
            cfg_ff[csr_idx] <= pwdata;
            valid_ff        <= 1'b0;
         end
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  pos_ff  <= pos_eff + PB'(1);
                  lane_ff <= pos_eff[1:0];
                  word_ff <= pos_eff[5:2];
                  data_ff <= req_data.data_in;
                  last_ff <= req_data.last_in;
                  if (hit) begin
                     state_ff <= S_LOOK;
                  end else begin
                     blk_ff   <= blk_eff;
                     start_ff <= 1'b1;
                     state_ff <= S_GEN;
                  end
               end
            end
            S_GEN: begin
               if (gen_done) begin
                  valid_ff  <= 1'b1;
                  cached_ff <= blk_ff;
                  state_ff  <= S_LOOK;
               end
            end
            S_LOOK: begin
               // Hold the RAM output until the response register frees up.
               if (load) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_data_ff.data_out <= data_ff ^ ks_byte;
                  rsp_data_ff.last_out <= last_ff;
                  state_ff             <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CC20_ASSERT_IMPL(a_start_gen, clock, reset, start_ff, state_ff == S_GEN, "block start outside generate state")
   `CC20_ASSERT_IMPL(a_look_valid, clock, reset, state_ff == S_LOOK, valid_ff, "lookup without a cached block")
   `CC20_ASSERT_IMPL(a_done_gen, clock, reset, gen_done, state_ff == S_GEN, "block done outside generate state")
   `CC20_ASSERT_NEXT(a_accept_busy, clock, reset, req_accept, state_ff != S_IDLE, "request accepted but unit idle")

endmodule

// ===== sim/tb_chacha20_seekable_stream_cipher_unit.sv =====
// Self-checking testbench for the ChaCha20 seekable stream cipher unit.
module tb_chacha20_seekable_stream_cipher_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import cc20_pkg::*;

   localparam int POS_W       = POSITION_BITS_DEF;
   localparam int BLK_W       = POSITION_BITS_DEF - 6;
   localparam int CYCLE_LIMIT = 6_000_000;

   typedef bit [15:0][31:0] chacha_words_type;
   typedef bit [63:0][7:0]  keystream_bytes_type;

   typedef enum int {RX_OPEN, RX_EVERY_FOURTH, RX_RANDOM, RX_LONG_HOLD} rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [REG_W-1:0]      pwdata = '0;
   logic [REG_W-1:0]      prdata;
   logic                  pready;

   // cipher state as the predictor sees it
   bit [REG_W-1:0]      cipher_regs [NUM_REGS];
   bit [POS_W-1:0]      stream_pos;
   bit [BLK_W-1:0]      cached_index;
   bit                  cache_valid;
   keystream_bytes_type cached_block;

   rsp_type expected_cipher_out [$];

   int unsigned requests_sent;
   int unsigned seeks_sent;
   int unsigned responses_checked;
   int unsigned config_writes;
   int unsigned mismatch_count;
   int unsigned cycle_count;
   int unsigned burst_left;
   rx_mode_type rx_mode = RX_OPEN;

   chacha20_seekable_stream_cipher_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #6 clock = ~clock;

   function automatic bit [31:0] rotl32(bit [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic chacha_words_type quarter_round(chacha_words_type w,
                                                      int a, int b, int c, int d);
      w[a] += w[b]; w[d] = rotl32(w[d] ^ w[a], 16);
      w[c] += w[d]; w[b] = rotl32(w[b] ^ w[c], 12);
      w[a] += w[b]; w[d] = rotl32(w[d] ^ w[a], 8);
      w[c] += w[d]; w[b] = rotl32(w[b] ^ w[c], 7);
      return w;
   endfunction

   function automatic keystream_bytes_type chacha_block(bit [BLK_W-1:0] index);
      chacha_words_type    init;
      chacha_words_type    w;
      keystream_bytes_type ks;
      bit [63:0]           ctr;
      bit [31:0]           sum;
      ctr = cipher_regs[REG_CTR] + 64'(index);
      for (int i = 0; i < 4; i++) begin
         init[i]         = SIGMA[i];
         init[4 + 2 * i] = cipher_regs[REG_KEY0 + i][31:0];
         init[5 + 2 * i] = cipher_regs[REG_KEY0 + i][63:32];
      end
      init[12] = ctr[31:0];
      init[13] = ctr[63:32];
      init[14] = cipher_regs[REG_NONCE][31:0];
      init[15] = cipher_regs[REG_NONCE][63:32];
      w = init;
      for (int r = 0; r < DOUBLE_ROUNDS_DEF; r++) begin
         w = quarter_round(w, 0, 4, 8, 12);
         w = quarter_round(w, 1, 5, 9, 13);
         w = quarter_round(w, 2, 6, 10, 14);
         w = quarter_round(w, 3, 7, 11, 15);
         w = quarter_round(w, 0, 5, 10, 15);
         w = quarter_round(w, 1, 6, 11, 12);
         w = quarter_round(w, 2, 7, 8, 13);
         w = quarter_round(w, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) begin
         sum = w[i] + init[i];
         for (int j = 0; j < 4; j++) ks[4 * i + j] = sum[8 * j +: 8];
      end
      return ks;
   endfunction

   function automatic rsp_type predict_cipher_byte(req_type r);
      rsp_type          o;
      bit [BLK_W-1:0]   blk;
      if (r.seek) stream_pos = r.position;
      blk = stream_pos[POS_W-1:6];
      if (!cache_valid || blk != cached_index) begin
         cached_block = chacha_block(blk);
         cached_index = blk;
         cache_valid  = 1'b1;
      end
      o.data_out = r.data_in ^ cached_block[stream_pos[5:0]];
      o.last_out = r.last_in;
      stream_pos = stream_pos + 1'b1;
      return o;
   endfunction

   function automatic bit [63:0] pick_reg_value();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Sender: bursts of requests separated by random gaps, sometimes long ones.
   task automatic send_byte(input bit [7:0] data, input bit seek,
                            input bit [POS_W-1:0] position, input bit last);
      req_type     item;
      int unsigned gap;
      item.data_in  = data;
      item.seek     = seek;
      item.position = position;
      item.last_in  = last;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 1100) : $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      expected_cipher_out = {expected_cipher_out, predict_cipher_byte(item)};
      requests_sent++;
      if (seek) seeks_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_cipher_out.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input int index, input bit [63:0] value);
      wait_drained();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(8 * index);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      if (index < NUM_REGS) begin
         cipher_regs[index] = value;
         cache_valid        = 1'b0;
      end
      config_writes++;
   endtask

   task automatic write_all_regs(input bit [63:0] value);
      for (int i = 0; i < NUM_REGS; i++) write_reg(i, value);
   endtask

   // A seek (except in one of the six run kinds), then a run of sequential bytes; a few stray seeks break the run.
   task automatic send_run(output int unsigned count);
      int unsigned    len;
      int unsigned    kind;
      bit [POS_W-1:0] target;
      bit             seek;
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
      kind = $urandom_range(0, 5);
      case (kind)
         0:       target = {16'($urandom), 32'($urandom)};
         1:       target = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 130));
         2:       target = {stream_pos[POS_W-1:6], 6'($urandom)};
         3:       target = 48'($urandom_range(0, 300));
         default: target = {16'($urandom), 32'($urandom)};
      endcase
      for (int j = 0; j < len; j++) begin
         seek = (j == 0) ? (kind != 5) : ($urandom_range(0, 39) == 0);
         send_byte(8'($urandom), seek, (j == 0) ? target : {16'($urandom), 32'($urandom)},
                   (j == len - 1) || ($urandom_range(0, 15) == 0));
      end
      count = len;
   endtask

   task automatic test_reset_defaults();
      send_byte(8'h00, 1'b0, '0, 1'b0);
      send_byte(8'hFF, 1'b0, '1, 1'b1);
      send_byte(8'hA5, 1'b0, 48'h5555_5555_5555, 1'b0);
      send_byte(8'h5A, 1'b0, 48'hAAAA_AAAA_AAAA, 1'b1);
   endtask

   task automatic test_register_extremes();
      write_all_regs('1);
      // writes past the last register must change nothing
      write_reg(NUM_REGS, {$urandom, $urandom});
      write_reg(NUM_REGS + 1, '1);
      send_byte(8'h3C, 1'b1, 48'h1234_5678_9ABC, 1'b0);
      send_byte(8'hC3, 1'b0, '0, 1'b0);
      send_byte(8'hFF, 1'b0, '1, 1'b1);
   endtask

   task automatic test_position_wrap();
      // cross the top of the position range; the counter sum overflows as well
      send_byte(8'h11, 1'b1, 48'hFFFF_FFFF_FFFE, 1'b0);
      send_byte(8'h22, 1'b0, '0, 1'b0);
      send_byte(8'h33, 1'b0, '0, 1'b0);
      send_byte(8'h44, 1'b0, '0, 1'b1);
   endtask

   task automatic test_counter_overflow();
      write_reg(REG_CTR, 64'hFFFF_FFFF_FFFF_FFFE);
      send_byte(8'h00, 1'b1, 48'd63, 1'b0);
      send_byte(8'h80, 1'b0, '1, 1'b0);
      send_byte(8'h01, 1'b0, '0, 1'b0);
      send_byte(8'hFE, 1'b1, 48'd128, 1'b1);
   endtask

   task automatic test_seek_in_block();
      write_all_regs('0);
      write_reg(REG_NONCE, {$urandom, $urandom});
      send_byte(8'h00, 1'b1, 48'd200, 1'b0);
      send_byte(8'hFF, 1'b1, 48'd195, 1'b0);
      send_byte(8'h69, 1'b1, 48'd255, 1'b0);
      send_byte(8'h96, 1'b1, 48'd192, 1'b1);
   endtask

   task automatic test_random_stream();
      int unsigned phase_items;
      int unsigned run_items;
      bit          paused;
      paused = 1'b0;
      for (int phase = 0; phase < 6; phase++) begin
         for (int i = 0; i < NUM_REGS; i++) write_reg(i, pick_reg_value());
         if (phase % 3 == 1) write_reg(NUM_REGS + $urandom_range(0, 1), {$urandom, $urandom});
         phase_items = 0;
         while (phase_items < 90) begin
            send_run(run_items);
            phase_items += run_items;
            // hold the sender once until the pipe is empty
            if (phase == 3 && !paused && phase_items >= 50) begin
               wait_drained();
               paused = 1'b1;
            end
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_extremes();
      test_position_wrap();
      test_counter_overflow();
      test_seek_in_block();
      test_random_stream();
      wait_drained();
      repeat (40) @(posedge clock);
      $display("Sent %0d requests (%0d with seek) across %0d register writes.",
               requests_sent, seeks_sent, config_writes);
      $display("Checked %0d responses, %0d mismatches.", responses_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Receiver: check each response, then pick the next ready value.
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cipher_out.size() == 0) begin
            mismatch_count++;
            $error("response with no request pending: data_out %h last_out %b",
                   rsp_data.data_out, rsp_data.last_out);
         end else begin
            want = expected_cipher_out.pop_front();
            responses_checked++;
            if (rsp_data.data_out !== want.data_out) begin
               mismatch_count++;
               $error("data_out: expected %h, got %h", want.data_out, rsp_data.data_out);
            end
            if (rsp_data.last_out !== want.last_out) begin
               mismatch_count++;
               $error("last_out: expected %b, got %b", want.last_out, rsp_data.last_out);
            end
         end
      end
      if (cycle_count % 256 == 0) rx_mode <= rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN:         rsp_ready <= 1'b1;
         RX_EVERY_FOURTH: rsp_ready <= (cycle_count[1:0] != 2'd0);
         RX_RANDOM:       rsp_ready <= 1'($urandom_range(0, 1));
         default:         rsp_ready <= (cycle_count % 32 >= 24);
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d responses outstanding.",
                  cycle_count, expected_cipher_out.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
